// ----- rtl/core/lol_pkg.sv -----
// shared constants, types and helpers for the longest line of ones core
package lol_pkg;

    localparam int MAX_SIDE = 256;
    localparam int COL_W    = $clog2(MAX_SIDE);
    localparam int POS_W    = COL_W + 1;
    localparam int CFG_W    = 9;
    localparam int RUN_W    = 9;

    localparam logic [CFG_W-1:0] GRID_SIDE_RESET = CFG_W'(256);
    localparam logic [RUN_W-1:0] RUN_MAX         = {RUN_W{1'b1}};

    // one cell as placed in the raster, ready for the update stage
    typedef struct packed {
        logic             one;
        logic             last;
        logic [COL_W-1:0] col;
        logic             row_nz;
        logic             col_nz;
        logic             right_in;
    } t_pos_beat;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] col;
        logic [RUN_W-1:0] vert;
        logic [RUN_W-1:0] diag;
        logic [RUN_W-1:0] anti;
    } t_line_wr;

    typedef struct packed {
        logic [RUN_W-1:0] vert;
        logic [RUN_W-1:0] diag;
        logic [RUN_W-1:0] anti;
    } t_line_rd;

    typedef struct packed {
        logic             valid;
        logic             last;
        logic [RUN_W-1:0] best;
    } t_s1_status;

    function automatic logic [RUN_W-1:0] run_extend(input logic one,
                                                    input logic [RUN_W-1:0] prev);
        logic [RUN_W-1:0] res;
        if (!one) begin
            res = '0;
        end else if (prev == RUN_MAX) begin
            res = RUN_MAX;
        end else begin
            res = prev + RUN_W'(1);
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/lol_ifs.sv -----
// stream interfaces for the cell input and the run result

interface lol_cell_if;
    logic valid;
    logic ready;
    logic cell_is_one;
    logic frame_last;

    modport source (output valid, output cell_is_one, output frame_last, input ready);
    modport sink   (input valid, input cell_is_one, input frame_last, output ready);
endinterface

interface lol_run_if import lol_pkg::*; ;
    logic             valid;
    logic             ready;
    logic [RUN_W-1:0] longest_run;

    modport source (output valid, output longest_run, input ready);
    modport sink   (input valid, input longest_run, output ready);
endinterface

// ----- rtl/core/lol_raster_pos.sv -----
// raster position tracking and line store address generation
module lol_raster_pos import lol_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [POS_W-1:0] i_side,
    input  logic             i_accept,
    input  logic             i_cell_is_one,
    input  logic             i_frame_last,
    output t_pos_beat        o_beat,
    output logic [COL_W-1:0] o_rd_col,
    output logic [COL_W-1:0] o_rd_right
);

    logic [COL_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] n_row;
    logic [COL_W-1:0] n_col;

    logic [POS_W-1:0] col_w;
    logic [POS_W-1:0] row_w;
    logic [POS_W-1:0] col_p1;
    logic [POS_W-1:0] row_p1;
    logic             right_in;

    always_comb begin
        col_w = {1'b0, r_col};
        row_w = {1'b0, r_row};
        // a side shrink may leave the position outside the grid
        if (col_w >= i_side) begin
            col_w = '0;
            row_w = row_w + POS_W'(1);
        end
        if (row_w >= i_side) begin
            row_w = '0;
        end
        col_p1   = col_w + POS_W'(1);
        row_p1   = row_w + POS_W'(1);
        right_in = (col_p1 < i_side);

        if (i_frame_last) begin
            n_col = '0;
            n_row = '0;
        end else if (!right_in) begin
            n_col = '0;
            n_row = (row_p1 >= i_side) ? '0 : row_p1[COL_W-1:0];
        end else begin
            n_col = col_p1[COL_W-1:0];
            n_row = row_w[COL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    assign o_beat.one      = i_cell_is_one;
    assign o_beat.last     = i_frame_last;
    assign o_beat.col      = col_w[COL_W-1:0];
    assign o_beat.row_nz   = (row_w != '0);
    assign o_beat.col_nz   = (col_w != '0);
    assign o_beat.right_in = right_in;
    assign o_rd_col        = col_w[COL_W-1:0];
    assign o_rd_right      = col_p1[COL_W-1:0];

`ifndef SYNTHESIS
    a_frame_end_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_frame_last) |=> (r_row == '0 && r_col == '0))
        else $error("position not cleared after frame end");
`endif

endmodule

// ----- rtl/core/lol_line_store.sv -----
// per-column run stores of the previous row, with write-to-read forwarding
module lol_line_store import lol_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [COL_W-1:0] i_rd_col,
    input  logic [COL_W-1:0] i_rd_right,
    input  t_line_wr         i_wr,
    output t_line_rd         o_rd
);

    logic [RUN_W-1:0] r_vert_mem [MAX_SIDE];
    logic [RUN_W-1:0] r_diag_mem [MAX_SIDE];
    logic [RUN_W-1:0] r_anti_mem [MAX_SIDE];

    logic [RUN_W-1:0] r_vert_q;
    logic [RUN_W-1:0] r_diag_q;
    logic [RUN_W-1:0] r_anti_q;
    logic             r_fwd_col;
    logic             r_fwd_right;
    t_line_wr         r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_vert_mem[i_wr.col] <= i_wr.vert;
            r_diag_mem[i_wr.col] <= i_wr.diag;
            r_anti_mem[i_wr.col] <= i_wr.anti;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_vert_q <= r_vert_mem[i_rd_col];
            r_diag_q <= r_diag_mem[i_rd_col];
            r_anti_q <= r_anti_mem[i_rd_right];
            r_fwd    <= i_wr;
        end
    end

    // a write landing on the same edge as the read wins over the old entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_col   <= 1'b0;
            r_fwd_right <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_col   <= i_wr.en && (i_wr.col == i_rd_col);
            r_fwd_right <= i_wr.en && (i_wr.col == i_rd_right);
        end
    end

    assign o_rd.vert = r_fwd_col   ? r_fwd.vert : r_vert_q;
    assign o_rd.diag = r_fwd_col   ? r_fwd.diag : r_diag_q;
    assign o_rd.anti = r_fwd_right ? r_fwd.anti : r_anti_q;

`ifndef SYNTHESIS
    a_fwd_needs_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rd_en && !i_wr.en) |=> (!r_fwd_col && !r_fwd_right))
        else $error("forward flagged without a write");
`endif

endmodule

// ----- rtl/core/lol_run_update.sv -----
// update stage: extends the four runs, tracks the best run of the frame
module lol_run_update import lol_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_pos_beat  i_beat,
    input  logic       i_hold,
    input  t_line_rd   i_rd,
    output t_line_wr   o_wr,
    output t_s1_status o_status
);

    logic             r_s1_valid;
    t_pos_beat        r_s1;
    logic [RUN_W-1:0] r_horiz;
    logic [RUN_W-1:0] r_held;
    logic [RUN_W-1:0] r_best;

    logic             advance;
    logic [RUN_W-1:0] h;
    logic [RUN_W-1:0] v;
    logic [RUN_W-1:0] d;
    logic [RUN_W-1:0] a;
    logic [RUN_W-1:0] n_best;

    assign advance = r_s1_valid && !i_hold;

    always_comb begin
        h = run_extend(r_s1.one, r_s1.col_nz ? r_horiz : '0);
        v = run_extend(r_s1.one, r_s1.row_nz ? i_rd.vert : '0);
        d = run_extend(r_s1.one, (r_s1.row_nz && r_s1.col_nz) ? r_held : '0);
        a = run_extend(r_s1.one, (r_s1.row_nz && r_s1.right_in) ? i_rd.anti : '0);
        n_best = r_best;
        if (h > n_best) n_best = h;
        if (v > n_best) n_best = v;
        if (d > n_best) n_best = d;
        if (a > n_best) n_best = a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1 <= i_beat;
        end
    end

    // frame end clears the running state for the next frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_horiz <= '0;
            r_held  <= '0;
            r_best  <= '0;
        end else if (advance) begin
            r_horiz <= r_s1.last ? '0 : h;
            r_held  <= r_s1.last ? '0 : i_rd.diag;
            r_best  <= r_s1.last ? '0 : n_best;
        end
    end

    assign o_wr.en   = advance;
    assign o_wr.col  = r_s1.col;
    assign o_wr.vert = v;
    assign o_wr.diag = d;
    assign o_wr.anti = a;

    assign o_status.valid = r_s1_valid;
    assign o_status.last  = r_s1.last;
    assign o_status.best  = n_best;

`ifndef SYNTHESIS
    a_best_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !r_s1.last) |=> (r_best >= $past(r_best)))
        else $error("best run shrank inside a frame");
`endif

endmodule

// ----- rtl/core/longest_line_of_ones_core.sv -----
// top level of the longest line of ones core
//
// Cells of a square binary grid enter on i_cell in raster order, one beat
// per cell, with frame_last set on the bottom right cell. The length of the
// longest straight line of ones (row, column, diagonal or anti-diagonal)
// leaves on o_run, one beat per frame.
// i_cfg_we/i_cfg_wdata set the grid side (reset 256); write it only while
// the core is idle. A side of 0 acts as 1, above the store depth as the depth.
// Throughput is one cell per cycle while i_cell.ready is high: each cell
// reads the three per-column stores once at acceptance and writes them back
// as it leaves the update stage, with forwarding when consecutive cells touch
// the same column. The result passes from the update stage into the output
// register that drives o_run.
// Reset clears the position, the runs and the output valid flag; the stores
// need no clearing since the top row ignores what it reads from them.
// While a result waits on o_run, further cells are still taken until the
// next frame's last cell reaches the update stage; then i_cell.ready drops.
module longest_line_of_ones_core import lol_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    lol_cell_if.sink         i_cell,
    lol_run_if.source        o_run
);

    logic [CFG_W-1:0] r_grid_side;
    logic [POS_W-1:0] side_use;
    logic             r_out_valid;
    logic [RUN_W-1:0] r_out_run;

    logic             accept;
    logic             hold;
    t_pos_beat        beat;
    logic [COL_W-1:0] rd_col;
    logic [COL_W-1:0] rd_right;
    t_line_wr         line_wr;
    t_line_rd         line_rd;
    t_s1_status       s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_side <= GRID_SIDE_RESET;
        end else if (i_cfg_we) begin
            r_grid_side <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_grid_side == '0) begin
            side_use = POS_W'(1);
        end else if (32'(r_grid_side) > MAX_SIDE) begin
            side_use = POS_W'(MAX_SIDE);
        end else begin
            side_use = POS_W'(r_grid_side);
        end
    end

    // the update stage waits only when its frame result has nowhere to go
    assign hold         = s1.valid && s1.last && r_out_valid && !o_run.ready;
    assign i_cell.ready = !hold;
    assign accept       = i_cell.valid && !hold;

    lol_raster_pos u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_side        (side_use),
        .i_accept      (accept),
        .i_cell_is_one (i_cell.cell_is_one),
        .i_frame_last  (i_cell.frame_last),
        .o_beat        (beat),
        .o_rd_col      (rd_col),
        .o_rd_right    (rd_right)
    );

    lol_line_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_col   (rd_col),
        .i_rd_right (rd_right),
        .i_wr       (line_wr),
        .o_rd       (line_rd)
    );

    lol_run_update u_update (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_beat   (beat),
        .i_hold   (hold),
        .i_rd     (line_rd),
        .o_wr     (line_wr),
        .o_status (s1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1.valid && s1.last && !hold) begin
            r_out_valid <= 1'b1;
        end else if (o_run.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1.valid && s1.last && !hold) begin
            r_out_run <= s1.best;
        end
    end

    assign o_run.valid       = r_out_valid;
    assign o_run.longest_run = r_out_run;

`ifndef SYNTHESIS
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s1.valid && s1.last))
        else $error("result beat without a frame end");

    a_hold_keeps_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hold |=> (s1.valid && s1.last))
        else $error("update stage lost its beat while held");
`endif

endmodule

// ----- bench/longest_line_of_ones_core_test.sv -----
// self-checking testbench for the longest line of ones core
module longest_line_of_ones_core_test;
    import lol_pkg::*;

    localparam int unsigned RANDOM_CELLS  = 700;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned MAX_SHOWN     = 10;
    localparam int unsigned FRAME_CAP     = 600;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    logic             rx_hold = 1'b0;
    logic             rx_idle = 1'b1;
    bit               tx_idle = 1'b1;
    int unsigned      mismatches = 0;
    event             hold_go;

    lol_cell_if cell_bus ();
    lol_run_if  run_bus ();

    longest_line_of_ones_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_cell      (cell_bus),
        .o_run       (run_bus)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // predictor state: position, line buffers and the running best
    logic [CFG_W-1:0] side_reg;
    int unsigned      at_row;
    int unsigned      at_col;
    logic [RUN_W-1:0] horiz_len;
    logic [RUN_W-1:0] held_diag_len;
    logic [RUN_W-1:0] best_len;
    logic [RUN_W-1:0] vert_len [MAX_SIDE];
    logic [RUN_W-1:0] diag_len [MAX_SIDE];
    logic [RUN_W-1:0] anti_len [MAX_SIDE];
    logic [RUN_W-1:0] pending_longest [$];

    function automatic int unsigned side_in_force();
        if (side_reg == '0) return 1;
        if (side_reg > MAX_SIDE) return MAX_SIDE;
        return side_reg;
    endfunction

    function automatic logic [RUN_W-1:0] grow_run(input logic one,
                                                  input logic [RUN_W-1:0] prev);
        if (!one) return '0;
        return (prev == RUN_MAX) ? RUN_MAX : prev + 1'b1;
    endfunction

    function automatic void restart_frame();
        at_row        = 0;
        at_col        = 0;
        horiz_len     = '0;
        held_diag_len = '0;
        best_len      = '0;
    endfunction

    function automatic void clear_predictor();
        side_reg = GRID_SIDE_RESET;
        restart_frame();
        foreach (vert_len[k]) begin
            vert_len[k] = '0;
            diag_len[k] = '0;
            anti_len[k] = '0;
        end
    endfunction

    function automatic void trace_cell(input logic one, input logic last);
        int unsigned      side;
        int unsigned      r;
        int unsigned      c;
        logic [RUN_W-1:0] up;
        logic [RUN_W-1:0] up_left;
        logic [RUN_W-1:0] up_right;
        logic [RUN_W-1:0] h;
        logic [RUN_W-1:0] v;
        logic [RUN_W-1:0] d;
        logic [RUN_W-1:0] a;
        logic [RUN_W-1:0] old_diag;
        side = side_in_force();
        if (at_col >= side) begin
            at_col = 0;
            at_row++;
        end
        if (at_row >= side) at_row = 0;
        c = at_col;
        r = at_row;
        // top row and grid edges see zeros from outside
        up       = (r > 0) ? vert_len[c] : '0;
        up_left  = (r > 0 && c > 0) ? held_diag_len : '0;
        up_right = (r > 0 && c + 1 < side) ? anti_len[c + 1] : '0;
        h = grow_run(one, (c > 0) ? horiz_len : '0);
        v = grow_run(one, up);
        d = grow_run(one, up_left);
        a = grow_run(one, up_right);
        old_diag      = diag_len[c];
        horiz_len     = h;
        vert_len[c]   = v;
        diag_len[c]   = d;
        anti_len[c]   = a;
        held_diag_len = old_diag;
        if (h > best_len) best_len = h;
        if (v > best_len) best_len = v;
        if (d > best_len) best_len = d;
        if (a > best_len) best_len = a;
        if (last) begin
            pending_longest.push_back(best_len);
            restart_frame();
        end else begin
            at_col = c + 1;
            if (at_col >= side) begin
                at_col = 0;
                at_row = r + 1;
                if (at_row >= side) at_row = 0;
            end
        end
    endfunction

    // result checking
    always @(posedge clk) begin : check_results
        logic [RUN_W-1:0] want;
        if (rst_n && run_bus.valid === 1'b1 && run_bus.ready === 1'b1) begin
            if (pending_longest.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result beat: longest_run %0d", run_bus.longest_run);
            end else begin
                want = pending_longest.pop_front();
                if (run_bus.longest_run !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("longest_run mismatch: expected %0d, got %0d",
                                 want, run_bus.longest_run);
                end
            end
        end
    end

    // result ready: random gap before each beat while rx_idle is set, plus the long hold-off
    initial begin : drive_result_ready
        int unsigned gap_left;
        run_bus.ready <= 1'b0;
        gap_left = 0;
        forever begin
            @(posedge clk);
            if (run_bus.valid === 1'b1 && run_bus.ready === 1'b1)
                gap_left = rx_idle ? $urandom_range(0, 5) : 0;
            if (rx_hold) begin
                run_bus.ready <= 1'b0;
            end else if (gap_left != 0) begin
                run_bus.ready <= 1'b0;
                gap_left--;
            end else begin
                run_bus.ready <= 1'b1;
            end
        end
    end

    initial begin : result_hold_off
        forever begin
            @(hold_go);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
        end
    end

    task automatic send_cell(input logic one, input logic last);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 5) : 0;
        if (gap != 0) begin
            cell_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cell_bus.valid       <= 1'b1;
        cell_bus.cell_is_one <= one;
        cell_bus.frame_last  <= last;
        do @(posedge clk); while (cell_bus.ready !== 1'b1);
        trace_cell(one, last);
    endtask

    // cell i of the frame is bits[i], raster order, last beat marks the frame end
    task automatic send_bits(input int unsigned count, input logic [63:0] bits);
        for (int unsigned i = 0; i < count; i++)
            send_cell(bits[i], i == count - 1);
    endtask

    task automatic wait_idle();
        cell_bus.valid <= 1'b0;
        while (pending_longest.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_side(input logic [CFG_W-1:0] side);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= side;
        @(posedge clk);
        cfg_we    <= 1'b0;
        side_reg = side;
    endtask

    task automatic test_full_row_at_reset_side();
        for (int unsigned i = 0; i < MAX_SIDE; i++)
            send_cell(1'b1, i == MAX_SIDE - 1);
    endtask

    task automatic test_line_shapes();
        write_side(2);
        send_bits(4, 64'b0000);
        send_bits(4, 64'b1111);
        write_side(3);
        send_bits(9, 64'b100_010_001);
        send_bits(9, 64'b001_010_100);
        send_bits(9, 64'b100_100_100);
    endtask

    task automatic test_frame_marks();
        write_side(3);
        // last beat while the second row is still open
        send_bits(4, 64'b1111);
        // runs past the bottom right cell and wraps to the top row
        send_bits(13, 64'h1fff);
    endtask

    task automatic test_side_extremes();
        write_side(0);
        send_bits(3, 64'b111);
        write_side(1);
        send_bits(2, 64'b11);
        write_side(511);
        for (int unsigned i = 0; i < MAX_SIDE + 2; i++)
            send_cell($urandom_range(0, 3) != 0, i == MAX_SIDE + 1);
        write_side(MAX_SIDE + 1);
        send_bits(4, 64'b1011);
    endtask

    task automatic test_backpressure();
        write_side(2);
        tx_idle = 1'b0;
        rx_idle <= 1'b0;
        -> hold_go;
        repeat (40) send_bits(4, 64'($urandom_range(0, 15)));
        // sender pauses until every result is back
        wait_idle();
        tx_idle = 1'b1;
        rx_idle <= 1'b1;
    endtask

    task automatic test_random_frames();
        int unsigned sent;
        int unsigned side;
        int unsigned eff;
        int unsigned len;
        int unsigned density;
        sent = 0;
        while (sent < RANDOM_CELLS) begin
            case ($urandom_range(0, 19))
                0:       side = 0;
                1:       side = MAX_SIDE;
                2:       side = $urandom_range(MAX_SIDE + 1, (1 << CFG_W) - 1);
                3, 4:    side = $urandom_range(9, 16);
                default: side = $urandom_range(1, 8);
            endcase
            write_side(CFG_W'(side));
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle <= ($urandom_range(0, 3) != 0);
            eff = (side == 0) ? 1 : (side > MAX_SIDE) ? MAX_SIDE : side;
            repeat ($urandom_range(1, 4)) begin
                len = eff * eff;
                case ($urandom_range(0, 7))
                    0:       len = $urandom_range(1, len);
                    1:       len = len + $urandom_range(1, len);
                    default: ;
                endcase
                if (len > FRAME_CAP) len = $urandom_range(eff + 1, FRAME_CAP);
                case ($urandom_range(0, 4))
                    0:       density = 0;
                    1:       density = 35;
                    2:       density = 65;
                    3:       density = 90;
                    default: density = 100;
                endcase
                for (int unsigned i = 0; i < len; i++)
                    send_cell($urandom_range(0, 99) < density, i == len - 1);
                sent += len;
            end
        end
        tx_idle = 1'b1;
        rx_idle <= 1'b1;
    endtask

    initial begin
        clear_predictor();
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= '0;
        cell_bus.valid       <= 1'b0;
        cell_bus.cell_is_one <= 1'b0;
        cell_bus.frame_last  <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_full_row_at_reset_side();
        test_line_shapes();
        test_frame_marks();
        test_side_extremes();
        test_backpressure();
        test_random_frames();

        wait_idle();
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/lol_pkg.sv
rtl/core/lol_ifs.sv
rtl/core/lol_raster_pos.sv
rtl/core/lol_line_store.sv
rtl/core/lol_run_update.sv
rtl/core/longest_line_of_ones_core.sv
bench/longest_line_of_ones_core_test.sv
